// File: src/packed_yuv_format_converter_top_defines.svh
// Assertion helpers for the packed YUV format converter
`ifndef PACKED_YUV_FORMAT_CONVERTER_TOP_DEFINES_SVH
`define PACKED_YUV_FORMAT_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PYFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with a fixed delay in cycles, checked outside reset
`define PYFC_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// File: src/pyfc_pkg.sv
// ----------------------------------------------------------------------------
// pyfc_pkg
// Types and constants shared by the packed YUV format converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pyfc_pkg;

    localparam int unsigned SRC_BYTES = 12;
    localparam int unsigned DST_BYTES = 8;

    typedef logic [7:0] t_byte;
    typedef t_byte [SRC_BYTES-1:0] t_src;
    typedef t_byte [DST_BYTES-1:0] t_dst;

    localparam t_byte ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [4:0] {
        MODE_YUYV_TO_444    = 5'd0,
        MODE_444_TO_YUYV    = 5'd1,
        MODE_UYVY_TO_444    = 5'd2,
        MODE_444_TO_UYVY    = 5'd3,
        MODE_YUVA_TO_444    = 5'd4,
        MODE_AYUV_TO_444    = 5'd5,
        MODE_444_TO_YUVA    = 5'd6,
        MODE_444_TO_AYUV    = 5'd7,
        MODE_YUVA_TO_YUYV   = 5'd8,
        MODE_AYUV_TO_YUYV   = 5'd9,
        MODE_444_TO_411     = 5'd10,
        MODE_444_TO_YVU411  = 5'd11,
        MODE_411_TO_YUYV    = 5'd12,
        MODE_YUYV_TO_411    = 5'd13,
        MODE_YVYU_TO_411    = 5'd14,
        MODE_UYVY_TO_411    = 5'd15,
        MODE_VYUY_TO_411    = 5'd16,
        MODE_YUYV_TO_YVU411 = 5'd17,
        MODE_YVYU_TO_YVU411 = 5'd18,
        MODE_UYVY_TO_YVU411 = 5'd19,
        MODE_VYUY_TO_YVU411 = 5'd20
    } t_mode;

    typedef struct packed {
        logic       ok;
        logic [3:0] count;
        t_dst       bytes;
    } t_result;

endpackage

`default_nettype wire

// File: src/pyfc_shuffle.sv
// ----------------------------------------------------------------------------
// pyfc_shuffle
// Byte shuffle and chroma averaging for one source group.
// ----------------------------------------------------------------------------
`default_nettype none

module pyfc_shuffle (
    input  var pyfc_pkg::t_mode   i_mode,
    input  var pyfc_pkg::t_src    i_src,
    output var pyfc_pkg::t_result o_result
);

    function automatic pyfc_pkg::t_byte avg2(pyfc_pkg::t_byte a, pyfc_pkg::t_byte b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

    function automatic pyfc_pkg::t_byte avg4(pyfc_pkg::t_byte a, pyfc_pkg::t_byte b,
                                             pyfc_pkg::t_byte c, pyfc_pkg::t_byte d);
        logic [9:0] sum;
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return sum[9:2];
    endfunction

    function automatic pyfc_pkg::t_dst pack411(
        pyfc_pkg::t_byte y0, pyfc_pkg::t_byte y1, pyfc_pkg::t_byte y2, pyfc_pkg::t_byte y3,
        pyfc_pkg::t_byte ca0, pyfc_pkg::t_byte ca1, pyfc_pkg::t_byte cb0,
        pyfc_pkg::t_byte cb1);
        pyfc_pkg::t_dst d;
        d    = '0;
        d[0] = y0;
        d[1] = y1;
        d[2] = avg2(ca0, ca1);
        d[3] = y2;
        d[4] = y3;
        d[5] = avg2(cb0, cb1);
        return d;
    endfunction

    pyfc_pkg::t_src  s;
    pyfc_pkg::t_dst  d;
    pyfc_pkg::t_byte u4;
    pyfc_pkg::t_byte v4;
    logic [3:0]      n;
    logic            ok;

    assign s  = i_src;
    assign u4 = avg4(s[1], s[4], s[7], s[10]);
    assign v4 = avg4(s[2], s[5], s[8], s[11]);

    always_comb begin
        d  = '0;
        n  = 4'd0;
        ok = 1'b1;
        case (i_mode)
            pyfc_pkg::MODE_YUYV_TO_444: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[3];
                d[3] = s[2]; d[4] = s[1]; d[5] = s[3]; n = 4'd6;
            end
            pyfc_pkg::MODE_444_TO_YUYV: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[3]; d[3] = s[5]; n = 4'd4;
            end
            pyfc_pkg::MODE_UYVY_TO_444: begin
                d[0] = s[1]; d[1] = s[0]; d[2] = s[2];
                d[3] = s[3]; d[4] = s[0]; d[5] = s[2]; n = 4'd6;
            end
            pyfc_pkg::MODE_444_TO_UYVY: begin
                d[0] = s[1]; d[1] = s[0]; d[2] = s[5]; d[3] = s[3]; n = 4'd4;
            end
            pyfc_pkg::MODE_YUVA_TO_444: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[2]; n = 4'd3;
            end
            pyfc_pkg::MODE_AYUV_TO_444: begin
                d[0] = s[1]; d[1] = s[2]; d[2] = s[3]; n = 4'd3;
            end
            pyfc_pkg::MODE_444_TO_YUVA: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[2];
                d[3] = pyfc_pkg::ALPHA_OPAQUE; n = 4'd4;
            end
            pyfc_pkg::MODE_444_TO_AYUV: begin
                d[0] = pyfc_pkg::ALPHA_OPAQUE; d[1] = s[0];
                d[2] = s[1]; d[3] = s[2]; n = 4'd4;
            end
            pyfc_pkg::MODE_YUVA_TO_YUYV: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[4]; d[3] = s[6]; n = 4'd4;
            end
            pyfc_pkg::MODE_AYUV_TO_YUYV: begin
                d[0] = s[1]; d[1] = s[2]; d[2] = s[5]; d[3] = s[7]; n = 4'd4;
            end
            pyfc_pkg::MODE_444_TO_411: begin
                d[0] = s[0]; d[1] = s[3]; d[2] = u4;
                d[3] = s[6]; d[4] = s[9]; d[5] = v4; n = 4'd6;
            end
            pyfc_pkg::MODE_444_TO_YVU411: begin
                d[0] = s[0]; d[1] = s[3]; d[2] = v4;
                d[3] = s[6]; d[4] = s[9]; d[5] = u4; n = 4'd6;
            end
            pyfc_pkg::MODE_411_TO_YUYV: begin
                d[0] = s[0]; d[1] = s[2]; d[2] = s[1]; d[3] = s[5];
                d[4] = s[3]; d[5] = s[2]; d[6] = s[4]; d[7] = s[5]; n = 4'd8;
            end
            pyfc_pkg::MODE_YUYV_TO_411, pyfc_pkg::MODE_YVYU_TO_YVU411: begin
                d = pack411(s[0], s[2], s[4], s[6], s[1], s[5], s[3], s[7]);
                n = 4'd6;
            end
            pyfc_pkg::MODE_YVYU_TO_411, pyfc_pkg::MODE_YUYV_TO_YVU411: begin
                d = pack411(s[0], s[2], s[4], s[6], s[3], s[7], s[1], s[5]);
                n = 4'd6;
            end
            pyfc_pkg::MODE_UYVY_TO_411, pyfc_pkg::MODE_VYUY_TO_YVU411: begin
                d = pack411(s[1], s[3], s[5], s[7], s[0], s[4], s[2], s[6]);
                n = 4'd6;
            end
            pyfc_pkg::MODE_VYUY_TO_411, pyfc_pkg::MODE_UYVY_TO_YVU411: begin
                d = pack411(s[1], s[3], s[5], s[7], s[2], s[6], s[0], s[4]);
                n = 4'd6;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign o_result.ok    = ok;
    assign o_result.count = n;
    assign o_result.bytes = d;

endmodule

`default_nettype wire

// File: src/packed_yuv_format_converter_top.sv
// The input register captures an accepted group; the converted result is registered for o_done.
// Throughput: one transaction per cycle; busy stays low, so start may be held.
// The result register is the only output stage and o_done lasts one cycle.
// A mode of 21 or above drops the transaction with no o_done.
// Synchronous active-low reset clears the valid bits and sets the mode to 0.
// ----------------------------------------------------------------------------
// packed_yuv_format_converter_top
// Converts one packed YUV pixel group per cycle between 8-bit layouts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_yuv_format_converter_top_defines.svh"

module packed_yuv_format_converter_top (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_cfg_we,
    input  var logic [4:0]  i_cfg_wdata,
    input  var logic        start,
    output var logic        busy,
    input  var logic [63:0] i_group_low_bytes,
    input  var logic [31:0] i_group_high_bytes,
    input  var logic        i_line_end_in,
    output var logic        o_done,
    output var logic [63:0] o_packed_out_bytes,
    output var logic [3:0]  o_valid_byte_count,
    output var logic        o_line_end_out
);

    pyfc_pkg::t_mode   r_mode;
    logic              r_in_valid;
    pyfc_pkg::t_mode   r_in_mode;
    pyfc_pkg::t_src    r_in_src;
    logic              r_in_line_end;
    logic              r_done;
    pyfc_pkg::t_dst    r_out_bytes;
    logic [3:0]        r_out_count;
    logic              r_out_line_end;
    logic              n_in_valid;
    logic              n_done;
    pyfc_pkg::t_result conv;

    assign busy       = 1'b0;
    assign n_in_valid = start & ~busy;
    assign n_done     = r_in_valid & conv.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pyfc_pkg::MODE_YUYV_TO_444;
        end else if (i_cfg_we) begin
            r_mode <= pyfc_pkg::t_mode'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_valid) begin
            r_in_mode     <= r_mode;
            r_in_src      <= {i_group_high_bytes, i_group_low_bytes};
            r_in_line_end <= i_line_end_in;
        end
        if (n_done) begin
            r_out_bytes    <= conv.bytes;
            r_out_count    <= conv.count;
            r_out_line_end <= r_in_line_end;
        end
    end

    pyfc_shuffle u_shuffle (
        .i_mode   (r_in_mode),
        .i_src    (r_in_src),
        .o_result (conv)
    );

    assign o_done             = r_done;
    assign o_packed_out_bytes = r_out_bytes;
    assign o_valid_byte_count = r_out_count;
    assign o_line_end_out     = r_out_line_end;

    `PYFC_ASSERT_SAME(a_count_range, o_done, (o_valid_byte_count >= 4'd3) && (o_valid_byte_count <= 4'd8), "byte count out of range")
    `PYFC_ASSERT_SAME(a_upper_zero, o_done, (o_packed_out_bytes >> {o_valid_byte_count, 3'b000}) == 64'd0, "bytes above count not zero")
    `PYFC_ASSERT_DELAY(a_latency, start && !busy && (r_mode <= pyfc_pkg::MODE_VYUY_TO_YVU411), 2, o_done, "accepted transaction produced no result")

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packed YUV format converter. Each accepted
// group is converted by an in-bench predictor under the mode last written,
// and every o_done transaction is compared with the oldest prediction. A
// short directed table covers each conversion, the byte extremes and the
// undefined modes; random groups follow under shifting modes and idle rates.
// ----------------------------------------------------------------------------
module testbench;
    import pyfc_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 9;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          ITEMS_PER_RUN = 450;
    localparam int          SEGMENT_ITEMS = 40;
    localparam int          TIMEOUT       = 2_000_000;
    localparam logic [4:0]  MODE_UNDEF_LO = 5'd21;
    localparam logic [4:0]  MODE_UNDEF_HI = 5'd31;
    localparam logic [63:0] PAT_LO        = 64'h8877_6655_4433_2211;
    localparam logic [31:0] PAT_HI        = 32'hCCBB_AA99;
    localparam logic [63:0] ONES_LO       = '1;
    localparam logic [31:0] ONES_HI       = '1;

    typedef struct packed {
        logic [4:0]  mode;
        logic [63:0] lo;
        logic [31:0] hi;
        logic        line_end;
        logic        fixed;
        logic [63:0] fixed_bytes;
        logic [3:0]  fixed_count;
    } t_stim_row;

    typedef struct {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        line_end;
    } t_conv_group;

    localparam int ROW_COUNT = 25;
    localparam t_stim_row DIRECTED_ROWS [0:ROW_COUNT-1] = '{
        '{MODE_YUYV_TO_444,    '0,      '0,      1'b0, 1'b1, 64'h0,                  4'd6},
        '{MODE_YUYV_TO_444,    ONES_LO, ONES_HI, 1'b1, 1'b1, 64'h0000_FFFF_FFFF_FFFF, 4'd6},
        '{MODE_444_TO_YUYV,    PAT_LO,  PAT_HI,  1'b0, 1'b0, 64'h0,                  4'd0},
        '{MODE_UYVY_TO_444,    PAT_LO,  PAT_HI,  1'b1, 1'b0, 64'h0,                  4'd0},
        '{MODE_444_TO_UYVY,    PAT_LO,  PAT_HI,  1'b0, 1'b0, 64'h0,                  4'd0},
        '{MODE_YUVA_TO_444,    ONES_LO, ONES_HI, 1'b0, 1'b1, 64'h0000_0000_00FF_FFFF, 4'd3},
        '{MODE_AYUV_TO_444,    PAT_LO,  PAT_HI,  1'b1, 1'b0, 64'h0,                  4'd0},
        '{MODE_444_TO_YUVA,    '0,      '0,      1'b0, 1'b1, 64'h0000_0000_FF00_0000, 4'd4},
        '{MODE_444_TO_AYUV,    '0,      '0,      1'b1, 1'b1, 64'h0000_0000_0000_00FF, 4'd4},
        '{MODE_YUVA_TO_YUYV,   PAT_LO,  PAT_HI,  1'b0, 1'b0, 64'h0,                  4'd0},
        '{MODE_AYUV_TO_YUYV,   PAT_LO,  PAT_HI,  1'b1, 1'b0, 64'h0,                  4'd0},
        '{MODE_444_TO_411,     ONES_LO, ONES_HI, 1'b0, 1'b1, 64'h0000_FFFF_FFFF_FFFF, 4'd6},
        '{MODE_444_TO_411,     PAT_LO,  PAT_HI,  1'b1, 1'b0, 64'h0,                  4'd0},
        '{MODE_444_TO_YVU411,  PAT_LO,  PAT_HI,  1'b0, 1'b0, 64'h0,                  4'd0},
        '{MODE_411_TO_YUYV,    ONES_LO, ONES_HI, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8},
        '{MODE_YUYV_TO_411,    PAT_LO,  PAT_HI,  1'b0, 1'b0, 64'h0,                  4'd0},
        '{MODE_YVYU_TO_411,    PAT_LO,  PAT_HI,  1'b1, 1'b0, 64'h0,                  4'd0},
        '{MODE_UYVY_TO_411,    PAT_LO,  PAT_HI,  1'b0, 1'b0, 64'h0,                  4'd0},
        '{MODE_VYUY_TO_411,    PAT_LO,  PAT_HI,  1'b1, 1'b0, 64'h0,                  4'd0},
        '{MODE_YUYV_TO_YVU411, PAT_LO,  PAT_HI,  1'b0, 1'b0, 64'h0,                  4'd0},
        '{MODE_YVYU_TO_YVU411, PAT_LO,  PAT_HI,  1'b1, 1'b0, 64'h0,                  4'd0},
        '{MODE_UYVY_TO_YVU411, PAT_LO,  PAT_HI,  1'b0, 1'b0, 64'h0,                  4'd0},
        '{MODE_VYUY_TO_YVU411, PAT_LO,  PAT_HI,  1'b1, 1'b0, 64'h0,                  4'd0},
        '{MODE_UNDEF_LO,       PAT_LO,  PAT_HI,  1'b0, 1'b1, 64'h0,                  4'd0},
        '{MODE_UNDEF_HI,       PAT_LO,  PAT_HI,  1'b1, 1'b1, 64'h0,                  4'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_group_low_bytes = '0;
    logic [31:0] i_group_high_bytes = '0;
    logic        i_line_end_in = 1'b0;
    logic        o_done;
    logic [63:0] o_packed_out_bytes;
    logic [3:0]  o_valid_byte_count;
    logic        o_line_end_out;

    logic        row_fixed = 1'b0;
    logic [63:0] row_fixed_bytes = '0;
    logic [3:0]  row_fixed_count = '0;

    t_conv_group expected_groups [$];
    logic [4:0]  mode_shadow = '0;
    logic [4:0]  drive_mode = '0;
    int          mismatch_count = 0;
    int          groups_checked = 0;
    int          mode_writes = 0;
    int          segment_no = 0;

    packed_yuv_format_converter_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .start              (start),
        .busy               (busy),
        .i_group_low_bytes  (i_group_low_bytes),
        .i_group_high_bytes (i_group_high_bytes),
        .i_line_end_in      (i_line_end_in),
        .o_done             (o_done),
        .o_packed_out_bytes (o_packed_out_bytes),
        .o_valid_byte_count (o_valid_byte_count),
        .o_line_end_out     (o_line_end_out)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic t_dst pack_411(input t_src s, input int ly, input int ca, input int cb);
        t_dst d;
        logic [8:0] sum_a;
        logic [8:0] sum_b;
        d = '0;
        sum_a = {1'b0, s[ca]} + {1'b0, s[ca+4]};
        sum_b = {1'b0, s[cb]} + {1'b0, s[cb+4]};
        d[0] = s[ly];
        d[1] = s[ly+2];
        d[2] = sum_a[8:1];
        d[3] = s[ly+4];
        d[4] = s[ly+6];
        d[5] = sum_b[8:1];
        return d;
    endfunction

    function automatic bit convert_group(input logic [4:0] mode, input logic [63:0] lo,
                                         input logic [31:0] hi, output t_dst bytes,
                                         output logic [3:0] count);
        t_src s;
        t_dst d;
        logic [9:0] u_sum;
        logic [9:0] v_sum;
        s = {hi, lo};
        d = '0;
        count = '0;
        bytes = '0;
        if (mode > MODE_VYUY_TO_YVU411) begin
            return 1'b0;
        end
        u_sum = 10'(s[1]) + 10'(s[4]) + 10'(s[7]) + 10'(s[10]);
        v_sum = 10'(s[2]) + 10'(s[5]) + 10'(s[8]) + 10'(s[11]);
        case (t_mode'(mode))
            MODE_YUYV_TO_444: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[3];
                d[3] = s[2]; d[4] = s[1]; d[5] = s[3]; count = 4'd6;
            end
            MODE_444_TO_YUYV: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[3]; d[3] = s[5]; count = 4'd4;
            end
            MODE_UYVY_TO_444: begin
                d[0] = s[1]; d[1] = s[0]; d[2] = s[2];
                d[3] = s[3]; d[4] = s[0]; d[5] = s[2]; count = 4'd6;
            end
            MODE_444_TO_UYVY: begin
                d[0] = s[1]; d[1] = s[0]; d[2] = s[5]; d[3] = s[3]; count = 4'd4;
            end
            MODE_YUVA_TO_444: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[2]; count = 4'd3;
            end
            MODE_AYUV_TO_444: begin
                d[0] = s[1]; d[1] = s[2]; d[2] = s[3]; count = 4'd3;
            end
            MODE_444_TO_YUVA: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[2]; d[3] = ALPHA_OPAQUE; count = 4'd4;
            end
            MODE_444_TO_AYUV: begin
                d[0] = ALPHA_OPAQUE; d[1] = s[0]; d[2] = s[1]; d[3] = s[2]; count = 4'd4;
            end
            MODE_YUVA_TO_YUYV: begin
                d[0] = s[0]; d[1] = s[1]; d[2] = s[4]; d[3] = s[6]; count = 4'd4;
            end
            MODE_AYUV_TO_YUYV: begin
                d[0] = s[1]; d[1] = s[2]; d[2] = s[5]; d[3] = s[7]; count = 4'd4;
            end
            MODE_444_TO_411, MODE_444_TO_YVU411: begin
                d[0] = s[0]; d[1] = s[3]; d[3] = s[6]; d[4] = s[9];
                d[2] = (mode == MODE_444_TO_411) ? u_sum[9:2] : v_sum[9:2];
                d[5] = (mode == MODE_444_TO_411) ? v_sum[9:2] : u_sum[9:2];
                count = 4'd6;
            end
            MODE_411_TO_YUYV: begin
                d[0] = s[0]; d[1] = s[2]; d[2] = s[1]; d[3] = s[5];
                d[4] = s[3]; d[5] = s[2]; d[6] = s[4]; d[7] = s[5]; count = 4'd8;
            end
            MODE_YUYV_TO_411, MODE_YVYU_TO_YVU411: begin
                d = pack_411(s, 0, 1, 3); count = 4'd6;
            end
            MODE_YVYU_TO_411, MODE_YUYV_TO_YVU411: begin
                d = pack_411(s, 0, 3, 1); count = 4'd6;
            end
            MODE_UYVY_TO_411, MODE_VYUY_TO_YVU411: begin
                d = pack_411(s, 1, 0, 2); count = 4'd6;
            end
            default: begin
                d = pack_411(s, 1, 2, 0); count = 4'd6;
            end
        endcase
        bytes = d;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $time, field, got, want);
        mismatch_count++;
    endtask

    // monitor: check results, then predict accepted transactions, then track mode writes
    always @(posedge i_clk) begin
        t_conv_group exp_group;
        t_dst        pred_bytes;
        logic [3:0]  pred_count;
        if (!i_rst_n) begin
            mode_shadow = MODE_YUYV_TO_444;
        end else begin
            if (o_done === 1'b1) begin
                if (expected_groups.size() == 0) begin
                    report_mismatch("unexpected o_done", o_packed_out_bytes, '0);
                end else begin
                    exp_group = expected_groups.pop_front();
                    groups_checked++;
                    if (o_packed_out_bytes !== exp_group.bytes)
                        report_mismatch("packed bytes", o_packed_out_bytes, exp_group.bytes);
                    if (o_valid_byte_count !== exp_group.count)
                        report_mismatch("byte count", 64'(o_valid_byte_count),
                                        64'(exp_group.count));
                    if (o_line_end_out !== exp_group.line_end)
                        report_mismatch("line end", 64'(o_line_end_out),
                                        64'(exp_group.line_end));
                end
            end else if (o_done !== 1'b0) begin
                report_mismatch("o_done unknown", 64'(o_done), '0);
            end
            if (start && busy === 1'b0) begin
                if (row_fixed) begin
                    if (row_fixed_count != 0) begin
                        exp_group.bytes = row_fixed_bytes;
                        exp_group.count = row_fixed_count;
                        exp_group.line_end = i_line_end_in;
                        expected_groups.push_back(exp_group);
                    end
                end else if (convert_group(mode_shadow, i_group_low_bytes, i_group_high_bytes,
                                           pred_bytes, pred_count)) begin
                    exp_group.bytes = pred_bytes;
                    exp_group.count = pred_count;
                    exp_group.line_end = i_line_end_in;
                    expected_groups.push_back(exp_group);
                end
            end
            if (i_cfg_we) begin
                mode_shadow = i_cfg_wdata;
                mode_writes++;
            end
        end
    end

    task automatic set_mode(input logic [4:0] mode);
        start <= 1'b0;
        while (expected_groups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        drive_mode = mode;
    endtask

    task automatic send_group(input int idle_pct, input logic [63:0] lo, input logic [31:0] hi,
                              input logic le, input logic fixed, input logic [63:0] fixed_bytes,
                              input logic [3:0] fixed_count);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            i_group_low_bytes <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_group_low_bytes <= lo;
        i_group_high_bytes <= hi;
        i_line_end_in <= le;
        row_fixed <= fixed;
        row_fixed_bytes <= fixed_bytes;
        row_fixed_count <= fixed_count;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_random_group(input int idle_pct);
        logic [63:0] lo;
        logic [31:0] hi;
        lo = {$urandom, $urandom};
        hi = $urandom;
        case ($urandom_range(0, 9))
            0: lo = '0;
            1: lo = '1;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: hi = '0;
            1: hi = '1;
            default: ;
        endcase
        send_group(idle_pct, lo, hi, $urandom_range(0, 3) == 0, 1'b0, '0, '0);
    endtask

    task automatic run_random(input int idle_pct, input int items);
        int sent;
        int seg_len;
        logic [4:0] mode;
        sent = 0;
        while (sent < items) begin
            case (segment_no % 7)
                0: mode = MODE_YUYV_TO_444;
                3: mode = MODE_VYUY_TO_YVU411;
                default: mode = 5'($urandom_range(MODE_YUYV_TO_444, MODE_VYUY_TO_YVU411));
            endcase
            segment_no++;
            set_mode(mode);
            seg_len = (items - sent < SEGMENT_ITEMS) ? items - sent : SEGMENT_ITEMS;
            repeat (seg_len) send_random_group(idle_pct);
            sent += seg_len;
            if ($urandom_range(0, 4) == 0) begin
                set_mode(5'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI)));
                repeat (6) send_random_group(idle_pct);
            end
        end
    endtask

    initial begin
        int waited;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].mode != drive_mode) set_mode(DIRECTED_ROWS[r].mode);
            send_group(0, DIRECTED_ROWS[r].lo, DIRECTED_ROWS[r].hi, DIRECTED_ROWS[r].line_end,
                       DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].fixed_bytes,
                       DIRECTED_ROWS[r].fixed_count);
        end

        run_random(35, ITEMS_PER_RUN);
        run_random(59, ITEMS_PER_RUN);
        run_random(0, ITEMS_PER_RUN);
        start <= 1'b0;

        waited = 0;
        while (expected_groups.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_groups.size() != 0)
            report_mismatch("groups never returned", 64'(expected_groups.size()), '0);

        $display("Checked %0d converted groups over %0d mode writes (all 21 conversions,",
                 groups_checked, mode_writes);
        $display("undefined modes dropped, sender idle at 35%%, 59%% and 0%%)");
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #TIMEOUT;
        $display("Timeout after %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
